// ===== rtl/spot_pkg.sv =====
// Shared types and constants for the shape pair overlap test unit.
`default_nettype none

package spot_pkg;

  // Shape kind codes as they arrive on the input word.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_RECT   = 2'd2;

  // Which overlap test the pair needs.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_CC,
    MODE_CR,
    MODE_RR
  } mode_e;

  // Lengths are held in 1/32 units: centers are 17-bit signed, half sizes
  // 16-bit unsigned, box edges 18-bit signed.
  typedef struct packed {
    mode_e              mode;
    logic signed [16:0] p_cx;
    logic signed [16:0] p_cy;
    logic signed [16:0] q_cx;
    logic signed [16:0] q_cy;
    logic        [15:0] p_hw;
    logic        [15:0] q_hw;
    logic signed [17:0] p_l;
    logic signed [17:0] p_r;
    logic signed [17:0] p_t;
    logic signed [17:0] p_b;
    logic signed [17:0] q_l;
    logic signed [17:0] q_r;
    logic signed [17:0] q_t;
    logic signed [17:0] q_b;
  } geom_t;

  typedef struct packed {
    mode_e              mode;
    logic signed [18:0] dx;
    logic signed [18:0] dy;
    logic        [16:0] rad;
    logic               rr_hit;
  } delta_t;

  // A circle center far outside a box gives a distance term of just under
  // 2^17, so its square fits in the 36-bit fields.
  typedef struct packed {
    mode_e       mode;
    logic [35:0] dx2;
    logic [35:0] dy2;
    logic [33:0] r2;
    logic        rr_hit;
  } square_t;

endpackage

`default_nettype wire

// ===== rtl/spot_decode.sv =====
// First stage logic: shape decode, ordering and box edges.
`default_nettype none

module spot_decode import spot_pkg::*; (
  input  wire logic [1:0]  a_kind_i,
  input  wire logic [15:0] a_x_i,
  input  wire logic [15:0] a_y_i,
  input  wire logic [14:0] a_size_w_i,
  input  wire logic [14:0] a_size_h_i,
  input  wire logic [1:0]  b_kind_i,
  input  wire logic [15:0] b_x_i,
  input  wire logic [15:0] b_y_i,
  input  wire logic [14:0] b_size_w_i,
  input  wire logic [14:0] b_size_h_i,
  input  wire logic        same_object_i,
  output geom_t            geom_o
);

  logic signed [16:0] a_cx, a_cy, b_cx, b_cy;
  logic        [15:0] a_hw, a_hh, b_hw, b_hh;
  logic signed [17:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
  logic               a_ok, b_ok, swap;

  // A circle radius is doubled into 1/32 units; a full box size in 1/16
  // units already equals the half size in 1/32 units.
  always_comb begin
    a_cx = $signed({a_x_i, 1'b0});
    a_cy = $signed({a_y_i, 1'b0});
    b_cx = $signed({b_x_i, 1'b0});
    b_cy = $signed({b_y_i, 1'b0});
    if (a_kind_i == KIND_CIRCLE) begin
      a_hw = {a_size_w_i, 1'b0};
      a_hh = '0;
    end else begin
      a_hw = {1'b0, a_size_w_i};
      a_hh = {1'b0, a_size_h_i};
    end
    if (b_kind_i == KIND_CIRCLE) begin
      b_hw = {b_size_w_i, 1'b0};
      b_hh = '0;
    end else begin
      b_hw = {1'b0, b_size_w_i};
      b_hh = {1'b0, b_size_h_i};
    end
    a_l = {a_cx[16], a_cx} - $signed({2'b00, a_hw});
    a_r = {a_cx[16], a_cx} + $signed({2'b00, a_hw});
    a_t = {a_cy[16], a_cy} - $signed({2'b00, a_hh});
    a_b = {a_cy[16], a_cy} + $signed({2'b00, a_hh});
    b_l = {b_cx[16], b_cx} - $signed({2'b00, b_hw});
    b_r = {b_cx[16], b_cx} + $signed({2'b00, b_hw});
    b_t = {b_cy[16], b_cy} - $signed({2'b00, b_hh});
    b_b = {b_cy[16], b_cy} + $signed({2'b00, b_hh});
  end

  always_comb begin
    a_ok = (a_kind_i == KIND_CIRCLE) || (a_kind_i == KIND_RECT);
    b_ok = (b_kind_i == KIND_CIRCLE) || (b_kind_i == KIND_RECT);
    // In a mixed pair the circle always goes to the p side.
    swap = (a_kind_i == KIND_RECT) && (b_kind_i == KIND_CIRCLE);

    if (same_object_i || !a_ok || !b_ok) begin
      geom_o.mode = MODE_NONE;
    end else if (a_kind_i == b_kind_i) begin
      geom_o.mode = (a_kind_i == KIND_CIRCLE) ? MODE_CC : MODE_RR;
    end else begin
      geom_o.mode = MODE_CR;
    end

    if (swap) begin
      geom_o.p_cx = b_cx;  geom_o.p_cy = b_cy;  geom_o.p_hw = b_hw;
      geom_o.q_cx = a_cx;  geom_o.q_cy = a_cy;  geom_o.q_hw = a_hw;
      geom_o.p_l  = b_l;   geom_o.p_r  = b_r;   geom_o.p_t  = b_t;  geom_o.p_b = b_b;
      geom_o.q_l  = a_l;   geom_o.q_r  = a_r;   geom_o.q_t  = a_t;  geom_o.q_b = a_b;
    end else begin
      geom_o.p_cx = a_cx;  geom_o.p_cy = a_cy;  geom_o.p_hw = a_hw;
      geom_o.q_cx = b_cx;  geom_o.q_cy = b_cy;  geom_o.q_hw = b_hw;
      geom_o.p_l  = a_l;   geom_o.p_r  = a_r;   geom_o.p_t  = a_t;  geom_o.p_b = a_b;
      geom_o.q_l  = b_l;   geom_o.q_r  = b_r;   geom_o.q_t  = b_t;  geom_o.q_b = b_b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spot_delta.sv =====
// Second stage logic: distance terms, clamping and the box-box test.
`default_nettype none

module spot_delta import spot_pkg::*; (
  input  wire geom_t geom_i,
  output delta_t     delta_o
);

  logic signed [18:0] pcx, pcy, qcx, qcy;
  logic signed [18:0] ql, qr, qt, qb;
  logic signed [18:0] cr_dx, cr_dy;

  always_comb begin
    pcx = {{2{geom_i.p_cx[16]}}, geom_i.p_cx};
    pcy = {{2{geom_i.p_cy[16]}}, geom_i.p_cy};
    qcx = {{2{geom_i.q_cx[16]}}, geom_i.q_cx};
    qcy = {{2{geom_i.q_cy[16]}}, geom_i.q_cy};
    ql  = {geom_i.q_l[17], geom_i.q_l};
    qr  = {geom_i.q_r[17], geom_i.q_r};
    qt  = {geom_i.q_t[17], geom_i.q_t};
    qb  = {geom_i.q_b[17], geom_i.q_b};

    // Distance from the circle center to the closest point of the box.
    if (pcx < ql) begin
      cr_dx = pcx - ql;
    end else if (pcx > qr) begin
      cr_dx = pcx - qr;
    end else begin
      cr_dx = '0;
    end
    if (pcy < qt) begin
      cr_dy = pcy - qt;
    end else if (pcy > qb) begin
      cr_dy = pcy - qb;
    end else begin
      cr_dy = '0;
    end

    delta_o.mode   = geom_i.mode;
    delta_o.rr_hit = (geom_i.p_r >= geom_i.q_l) && (geom_i.p_l <= geom_i.q_r) &&
                     (geom_i.p_b >= geom_i.q_t) && (geom_i.p_t <= geom_i.q_b);
    if (geom_i.mode == MODE_CR) begin
      delta_o.dx  = cr_dx;
      delta_o.dy  = cr_dy;
      delta_o.rad = {1'b0, geom_i.p_hw};
    end else begin
      delta_o.dx  = qcx - pcx;
      delta_o.dy  = qcy - pcy;
      delta_o.rad = {1'b0, geom_i.p_hw} + {1'b0, geom_i.q_hw};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spot_square.sv =====
// Third stage logic: squares of the distance terms and the radius.
`default_nettype none

module spot_square import spot_pkg::*; (
  input  wire delta_t delta_i,
  output square_t     square_o
);

  logic signed [37:0] sq_x, sq_y;
  logic        [33:0] sq_r;

  always_comb begin
    sq_x = delta_i.dx * delta_i.dx;
    sq_y = delta_i.dy * delta_i.dy;
    sq_r = delta_i.rad * delta_i.rad;
    square_o.mode   = delta_i.mode;
    square_o.rr_hit = delta_i.rr_hit;
    square_o.dx2    = sq_x[35:0];
    square_o.dy2    = sq_y[35:0];
    square_o.r2     = sq_r;
  end

endmodule

`default_nettype wire

// ===== rtl/shape_pair_overlap_test_unit.sv =====
// Shape pair overlap test unit: circle and box collision flag, four-stage pipeline.
// Throughput is one word per cycle while the output is not stalled; each stage
// has its own valid bit, so a stall on the output only holds the stages that
// are full and bubbles close up behind it.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module shape_pair_overlap_test_unit import spot_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  a_kind_i,
  input  wire logic [15:0] a_x_i,
  input  wire logic [15:0] a_y_i,
  input  wire logic [14:0] a_size_w_i,
  input  wire logic [14:0] a_size_h_i,
  input  wire logic [1:0]  b_kind_i,
  input  wire logic [15:0] b_x_i,
  input  wire logic [15:0] b_y_i,
  input  wire logic [14:0] b_size_w_i,
  input  wire logic [14:0] b_size_h_i,
  input  wire logic        same_object_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o
);

  // Stage 1 holds decoded geometry with box edges, stage 2 the distance terms,
  // stage 3 the squares, and stage 4 the final compare, which is the output word.
  geom_t   geom_d,   geom_q;
  delta_t  delta_d,  delta_q;
  square_t square_d, square_q;
  logic    hit_d,    hit_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // The sum of two 36-bit squares needs one more bit.
  logic [36:0] dist2;
  logic [36:0] lim2;

  spot_decode u_decode (
    .a_kind_i      (a_kind_i),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_size_w_i    (a_size_w_i),
    .a_size_h_i    (a_size_h_i),
    .b_kind_i      (b_kind_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .b_size_w_i    (b_size_w_i),
    .b_size_h_i    (b_size_h_i),
    .same_object_i (same_object_i),
    .geom_o        (geom_d)
  );

  spot_delta u_delta (
    .geom_i  (geom_q),
    .delta_o (delta_d)
  );

  spot_square u_square (
    .delta_i  (delta_q),
    .square_o (square_d)
  );

  // The final compare is inclusive: touching shapes count as a hit.
  always_comb begin
    dist2 = {1'b0, square_q.dx2} + {1'b0, square_q.dy2};
    lim2  = {3'b000, square_q.r2};
    unique case (square_q.mode)
      MODE_NONE: hit_d = 1'b0;
      MODE_RR:   hit_d = square_q.rr_hit;
      MODE_CC,
      MODE_CR:   hit_d = (dist2 <= lim2);
      default:   hit_d = 1'b0;
    endcase
  end

  // A stage can take a new word when it is empty or its word moves on.
  always_comb begin
    rdy4 = !v4_q || !out_stall_i;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign hit_o       = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) geom_q   <= geom_d;
    if (rdy2 && v1_q)       delta_q  <= delta_d;
    if (rdy3 && v2_q)       square_q <= square_d;
    if (rdy4 && v3_q)       hit_q    <= hit_d;
  end

endmodule

`default_nettype wire

// ===== dv/shape_pair_overlap_test_unit_tb.sv =====
// Self-checking testbench for the shape pair overlap test unit.
`timescale 1ns / 1ps

module shape_pair_overlap_test_unit_tb;
  import spot_pkg::*;

  // The kind field has one code that the package does not name; the block
  // must treat it like an empty layer.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_WORDS = 1050;
  // Idling is picked per phase, and the phase moves on every PHASE_WORDS words.
  localparam int unsigned PHASE_WORDS  = 96;
  // The pipeline is four stages deep; after the last result the bench waits
  // on so that any stray result word still shows up.
  localparam int unsigned DRAIN_CYCLES = 12;
  // Cycles in a row with no word moving on either side before the run is
  // declared hung. Even with either side idling half the time a gap of this
  // length does not happen in a correct run.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned REPORT_LIMIT = 10;

  // Percent chance of idling per cycle in each phase: no idling, sender idle,
  // receiver stalling, both.
  localparam int unsigned SEND_IDLE_PCT [4] = '{0, 50, 0, 31};
  localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 50, 31};

  // One shape as it arrives on the input word.
  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
  } shape_word_t;

  typedef struct {
    shape_word_t a;
    shape_word_t b;
    logic        same_object;
  } pair_word_t;

  // A shape with every length in 1/32 units: centers doubled, a box's full
  // size in 1/16 is its half size in 1/32, a radius is doubled.
  typedef struct {
    logic [1:0] kind;
    longint     cx;
    longint     cy;
    longint     hw;
    longint     hh;
  } shape_geom_t;

  typedef struct {
    pair_word_t word;
    logic       hit;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         a_kind_i      = '0;
  logic [15:0]        a_x_i         = '0;
  logic [15:0]        a_y_i         = '0;
  logic [14:0]        a_size_w_i    = '0;
  logic [14:0]        a_size_h_i    = '0;
  logic [1:0]         b_kind_i      = '0;
  logic [15:0]        b_x_i         = '0;
  logic [15:0]        b_y_i         = '0;
  logic [14:0]        b_size_w_i    = '0;
  logic [14:0]        b_size_h_i    = '0;
  logic               same_object_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               hit_o;

  pair_word_t  pending_words[$];
  verdict_t    expected_verdicts[$];
  pair_word_t  driven_word;
  int unsigned accepted_words  = 0;
  int unsigned delivered_words = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  shape_pair_overlap_test_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .a_kind_i      (a_kind_i),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_size_w_i    (a_size_w_i),
    .a_size_h_i    (a_size_h_i),
    .b_kind_i      (b_kind_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .b_size_w_i    (b_size_w_i),
    .b_size_h_i    (b_size_h_i),
    .same_object_i (same_object_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Overlap predictor. All arithmetic is done in 64 bits, where every square
  // and sum of the block's widths is exact.
  // ---------------------------------------------------------------------------

  function automatic shape_geom_t to_geom(shape_word_t s);
    shape_geom_t g;
    g.kind = s.kind;
    g.cx   = 2 * longint'(s.x);
    g.cy   = 2 * longint'(s.y);
    g.hw   = longint'(s.size_w);
    g.hh   = longint'(s.size_h);
    // A circle has only a radius; its height field carries no meaning.
    if (s.kind == KIND_CIRCLE) begin
      g.hw = 2 * g.hw;
      g.hh = 0;
    end
    return g;
  endfunction

  // The circle center is clamped into the box to find the closest point of
  // the box, and that point must lie within the radius.
  function automatic logic circle_meets_box(shape_geom_t c, shape_geom_t r);
    longint near_x;
    longint near_y;
    longint dx;
    longint dy;
    near_x = c.cx;
    near_y = c.cy;
    if (near_x < r.cx - r.hw) begin
      near_x = r.cx - r.hw;
    end else if (near_x > r.cx + r.hw) begin
      near_x = r.cx + r.hw;
    end
    if (near_y < r.cy - r.hh) begin
      near_y = r.cy - r.hh;
    end else if (near_y > r.cy + r.hh) begin
      near_y = r.cy + r.hh;
    end
    dx = c.cx - near_x;
    dy = c.cy - near_y;
    return (dx * dx + dy * dy <= c.hw * c.hw);
  endfunction

  function automatic logic predict_hit(pair_word_t p);
    shape_geom_t a;
    shape_geom_t b;
    longint      dx;
    longint      dy;
    longint      reach;
    a = to_geom(p.a);
    b = to_geom(p.b);
    // An empty layer, the unused kind code, or a shape paired with itself
    // never collides.
    if (p.same_object) return 1'b0;
    if (a.kind != KIND_CIRCLE && a.kind != KIND_RECT) return 1'b0;
    if (b.kind != KIND_CIRCLE && b.kind != KIND_RECT) return 1'b0;
    if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE) begin
      dx    = b.cx - a.cx;
      dy    = b.cy - a.cy;
      reach = a.hw + b.hw;
      return (dx * dx + dy * dy <= reach * reach);
    end
    if (a.kind == KIND_RECT && b.kind == KIND_RECT) begin
      // Touching edges count as overlap on each axis.
      return (a.cx + a.hw >= b.cx - b.hw) && (a.cx - a.hw <= b.cx + b.hw) &&
             (a.cy + a.hh >= b.cy - b.hh) && (a.cy - a.hh <= b.cy + b.hh);
    end
    if (a.kind == KIND_CIRCLE) return circle_meets_box(a, b);
    return circle_meets_box(b, a);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic pair_word_t make_pair(
    logic [1:0] ak, int ax, int ay, int aw, int ah,
    logic [1:0] bk, int bx, int by, int bw, int bh, logic same);
    pair_word_t p;
    p.a.kind   = ak;
    p.a.x      = 16'(ax);
    p.a.y      = 16'(ay);
    p.a.size_w = 15'(aw);
    p.a.size_h = 15'(ah);
    p.b.kind   = bk;
    p.b.x      = 16'(bx);
    p.b.y      = 16'(by);
    p.b.size_w = 15'(bw);
    p.b.size_h = 15'(bh);
    p.same_object = same;
    return p;
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Mostly small shapes so that hits and misses both come up often; now and
  // then a medium or a full-range size.
  function automatic logic [14:0] random_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 15'($urandom_range(0, 511));
    if (roll < 90) return 15'($urandom_range(0, 4095));
    return 15'($urandom);
  endfunction

  function automatic shape_word_t random_shape();
    shape_word_t s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      s.kind = KIND_NONE;
    end else if (roll < 7) begin
      s.kind = KIND_SPARE;
    end else if (roll < 52) begin
      s.kind = KIND_CIRCLE;
    end else begin
      s.kind = KIND_RECT;
    end
    s.x      = 16'($urandom);
    s.y      = 16'($urandom);
    s.size_w = random_size();
    s.size_h = random_size();
    return s;
  endfunction

  // Extent of a shape from its center, in 1/32 units, along each axis.
  function automatic int extent_x(shape_word_t s);
    return (s.kind == KIND_CIRCLE) ? 2 * int'(s.size_w) : int'(s.size_w);
  endfunction

  function automatic int extent_y(shape_word_t s);
    return (s.kind == KIND_CIRCLE) ? 2 * int'(s.size_w) : int'(s.size_h);
  endfunction

  function automatic int random_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Most pairs put the second shape within reach of the first, some exactly
  // at the touching distance give or take one step, and the rest are
  // scattered over the whole plane.
  function automatic pair_word_t random_pair();
    pair_word_t  p;
    int unsigned roll;
    int          reach;
    int          nudge;
    p.a = random_shape();
    p.b = random_shape();
    p.same_object = ($urandom_range(0, 99) < 5);
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      // An even box width keeps the touching distance a whole Q12.4 step.
      if (p.a.kind == KIND_RECT) p.a.size_w[0] = 1'b0;
      if (p.b.kind == KIND_RECT) p.b.size_w[0] = 1'b0;
      reach = (extent_x(p.a) + extent_x(p.b)) / 2;
      nudge = int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) != 0) begin
        p.b.x = clamp16(int'(p.a.x) + reach + nudge);
      end else begin
        p.b.x = clamp16(int'(p.a.x) - reach - nudge);
      end
      p.b.y = p.a.y;
    end else if (roll < 80) begin
      p.b.x = clamp16(int'(p.a.x) +
                      random_offset((extent_x(p.a) + extent_x(p.b)) / 2 + 2));
      p.b.y = clamp16(int'(p.a.y) +
                      random_offset((extent_y(p.a) + extent_y(p.b)) / 2 + 2));
    end
    return p;
  endfunction

  task automatic note_failure(string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%t ERROR: %s", $realtime, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the oldest pending word and predicts the result of each
  // word at the edge where the block takes it. A new word is only loaded when
  // the port is free, so a stalled word stays put.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_verdicts.push_back('{word: driven_word, hit: predict_hit(driven_word)});
        accepted_words++;
      end
      if (!in_valid_i || in_fire) begin
        if (pending_words.size() != 0 &&
            $urandom_range(0, 99) >= SEND_IDLE_PCT[(accepted_words / PHASE_WORDS) % 4]) begin
          driven_word = pending_words.pop_front();
          a_kind_i      <= driven_word.a.kind;
          a_x_i         <= driven_word.a.x;
          a_y_i         <= driven_word.a.y;
          a_size_w_i    <= driven_word.a.size_w;
          a_size_h_i    <= driven_word.a.size_h;
          b_kind_i      <= driven_word.b.kind;
          b_x_i         <= driven_word.b.x;
          b_y_i         <= driven_word.b.y;
          b_size_w_i    <= driven_word.b.size_w;
          b_size_h_i    <= driven_word.b.size_h;
          same_object_i <= driven_word.same_object;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result word taken from the block is checked against the
  // oldest prediction. The stall for the next cycle is drawn here as well.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    verdict_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("result word hit=%0b with no input word pending", hit_o));
        end else begin
          want = expected_verdicts.pop_front();
          if (hit_o !== want.hit) begin
            note_failure($sformatf(
              "hit expected %0b, got %b; a: kind %0d (%0d,%0d) %0d x %0d, b: kind %0d (%0d,%0d) %0d x %0d, same %0b",
              want.hit, hit_o,
              want.word.a.kind, want.word.a.x, want.word.a.y,
              want.word.a.size_w, want.word.a.size_h,
              want.word.b.kind, want.word.b.x, want.word.b.y,
              want.word.b.size_w, want.word.b.size_h, want.word.same_object));
          end
        end
        delivered_words++;
      end
      out_stall_i <= ($urandom_range(0, 99) < RECV_STALL_PCT[(delivered_words / PHASE_WORDS) % 4]);
    end
  end

  // Watchdog: a run in which no word moves for too long is hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("shape_pair_overlap_test_unit_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    // An empty layer on either side, and the unused kind code, never hit even
    // when the shapes sit on top of each other.
    pending_words.push_back(make_pair(KIND_NONE, 0, 0, 100, 100, KIND_CIRCLE, 0, 0, 100, 0, 0));
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_NONE, 0, 0, 100, 100, 0));
    pending_words.push_back(make_pair(KIND_SPARE, 0, 0, 100, 100, KIND_RECT, 0, 0, 100, 100, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 100, 0, KIND_SPARE, 5, 5, 100, 100, 0));
    pending_words.push_back(make_pair(KIND_NONE, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 0, 0));
    // The same object paired with itself is never a hit.
    pending_words.push_back(make_pair(KIND_CIRCLE, 10, 10, 50, 0, KIND_CIRCLE, 12, 10, 50, 0, 1));
    pending_words.push_back(make_pair(KIND_RECT, -7, 3, 80, 80, KIND_RECT, -7, 3, 80, 80, 1));
    // Two circles exactly touching, then one step apart; the height of a
    // circle is ignored, so it is set to its widest value here.
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 16, 32767, KIND_CIRCLE, 32, 0, 16, 0, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 16, 0, KIND_CIRCLE, 33, 0, 16, 32767, 0));
    // A 3-4-5 triangle between the centers, exactly at the radius sum.
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 5, 0, KIND_CIRCLE, 3, 4, 0, 0, 0));
    // Largest circles in opposite corners, and zero-radius circles on the
    // same extreme point.
    pending_words.push_back(make_pair(KIND_CIRCLE, -32768, -32768, 32767, 0,
                                      KIND_CIRCLE, 32767, 32767, 32767, 0, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, -32768, 32767, 0, 0,
                                      KIND_CIRCLE, -32768, 32767, 0, 0, 0));
    // Boxes sharing a vertical edge, then one step apart, then sharing the
    // bottom edge of the second box.
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 32, 32, KIND_RECT, 32, 0, 32, 32, 0));
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 32, 32, KIND_RECT, 33, 0, 32, 32, 0));
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 32, 32, KIND_RECT, 0, -32, 32, 32, 0));
    // Largest boxes: one 1/32 unit short of touching a point, and a point at the
    // center of a largest box in the far corner.
    pending_words.push_back(make_pair(KIND_RECT, -32768, -32768, 32767, 32767,
                                      KIND_RECT, -16384, -16384, 0, 0, 0));
    pending_words.push_back(make_pair(KIND_RECT, 32767, 32767, 32767, 32767,
                                      KIND_RECT, 32767, 32767, 0, 0, 0));
    // Circle inside a box, circle touching a box corner from either order,
    // and a circle one step too small for that corner.
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 1, 0, KIND_RECT, 0, 0, 320, 160, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, 19, 20, 5, 0, KIND_RECT, 0, 0, 32, 32, 0));
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 32, 32, KIND_CIRCLE, 19, 20, 5, 0, 0));
    pending_words.push_back(make_pair(KIND_RECT, 0, 0, 32, 32, KIND_CIRCLE, 19, 20, 4, 0, 0));
    // Circle left of a box: touching, short by one step, and far away.
    pending_words.push_back(make_pair(KIND_CIRCLE, -20, 0, 4, 0, KIND_RECT, 0, 0, 32, 32, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, -20, 0, 3, 0, KIND_RECT, 0, 0, 32, 32, 0));
    pending_words.push_back(make_pair(KIND_CIRCLE, 0, 0, 16, 0, KIND_RECT, 100, 0, 32, 32, 0));
    // All ones on every field.
    pending_words.push_back(make_pair(KIND_SPARE, -1, -1, 32767, 32767,
                                      KIND_SPARE, -1, -1, 32767, 32767, 1));

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      pending_words.push_back(random_pair());
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken, then for every result to come back,
    // then a little longer for anything the block should not have sent.
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_verdicts.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_verdicts.size()));
    end
    if (error_count == 0) begin
      $display("shape_pair_overlap_test_unit_tb: clean");
    end else begin
      $display("shape_pair_overlap_test_unit_tb: errors");
    end
    $finish;
  end

endmodule
